// ===== src/triangle_tangent_bitangent_defines.svh =====
// ----------------------------------------------------------------------------
// Triangle tangent/bitangent assertion macros
// Shared property forms for the checker of the tangent/bitangent block.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_BITANGENT_DEFINES_SVH
`define TRIANGLE_TANGENT_BITANGENT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TBT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TBT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/tbt_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle tangent/bitangent package
// Types, widths and helpers shared by the block's modules.
// ----------------------------------------------------------------------------
package tbt_pkg;

	localparam int CORNER_W = 10;
	localparam int POS_W    = 32;
	localparam int TEX_W    = 16;
	localparam int VTX_W    = 3 * POS_W + 2 * TEX_W;

	// Edge and UV delta widths, one bit over the source fields.
	localparam int OPA_W    = POS_W + 1;
	localparam int OPB_W    = TEX_W + 1;
	localparam int PROD_W   = OPA_W + OPB_W;
	localparam int NUM_W    = PROD_W + 1;
	localparam int DEN_W    = 2 * OPB_W + 1;
	localparam int QUO_W    = 32;
	localparam int FRAC_SH  = 12;

	localparam int IN_DATA_W  = 160;
	localparam int OUT_DATA_W = 6 * QUO_W;

	localparam logic REQ_WRITE   = 1'b0;
	localparam logic REQ_COMPUTE = 1'b1;

	// Quantity sequence: determinant first, then three tangent and three
	// bitangent numerators.
	localparam logic [2:0] QTY_DET   = 3'd0;
	localparam logic [2:0] QTY_BIT0  = 3'd4;
	localparam logic [2:0] QTY_LAST  = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_RD_C,
		ST_CAP,
		ST_MUL,
		ST_ACC,
		ST_DIV,
		ST_DWAIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] num;
		logic signed [DEN_W-1:0] den;
	} div_req_t;

	// Reduces a corner index modulo the table depth by restoring subtraction
	// of shifted multiples; the quotient is below 256 only for depths of 4 or more.
	function automatic logic [CORNER_W-1:0] slot_mod(input logic [CORNER_W-1:0] idx,
		input int unsigned slots);
		logic [31:0] x;
		x = {{(32-CORNER_W){1'b0}}, idx};
		for (int k = 7; k >= 0; k--) begin
			if (x >= (slots << k)) begin
				x = x - (slots << k);
			end
		end
		return x[CORNER_W-1:0];
	endfunction

endpackage

// ===== src/triangle_tangent_bitangent.sv =====
// A vertex write leaves the block idle, and it stays ready for the next item.
// A triangle's result follows its transfer through the three vertex-table reads and a
// capture, the seven two-term sums (a multiply and an accumulate step per term), six
// divisions in the one-bit-per-cycle divider and an output state.
// A degenerate triangle ends after the determinant. Input is ready in the same cycle that
// the result appears; a stalled result keeps the next triangle in its output state until taken.
// ----------------------------------------------------------------------------
// Triangle tangent/bitangent unit
// Stores vertices and computes a triangle's tangent and bitangent in Q16.16.
// ----------------------------------------------------------------------------
module triangle_tangent_bitangent #(
	parameter int VERTEX_SLOTS = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// corner_a, corner_b, corner_c, pos_x, pos_y, pos_z, tex_u, tex_v, zero fill
	input  logic [tbt_pkg::IN_DATA_W-1:0]        s_axis_tdata,
	// req_type
	input  logic                                 s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z
	output logic [tbt_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	// degenerate
	output logic                                 m_axis_tuser
);

	localparam int AW  = $clog2(VERTEX_SLOTS);
	localparam int CW  = tbt_pkg::CORNER_W;
	localparam int PW  = tbt_pkg::POS_W;
	localparam int TW  = tbt_pkg::TEX_W;
	localparam int VW  = tbt_pkg::VTX_W;
	localparam int AOW = tbt_pkg::OPA_W;
	localparam int BOW = tbt_pkg::OPB_W;
	localparam int PRW = tbt_pkg::PROD_W;
	localparam int NW  = tbt_pkg::NUM_W;
	localparam int DW  = tbt_pkg::DEN_W;
	localparam int QW  = tbt_pkg::QUO_W;

	tbt_pkg::state_t state_q, state_d;

	logic                 in_xfer;
	logic                 out_free;
	logic [CW-1:0]        sa_mod, sb_mod, sc_mod;
	logic [AW+CW-1:0]     sa_ext, sb_ext, sc_ext;
	logic [AW-1:0]        a_q, b_q, c_q;
	logic                 ram_we;
	logic [AW-1:0]        ram_raddr;
	logic [VW-1:0]        ram_rdata;
	logic [VW-1:0]        wr_vtx;
	logic [VW-1:0]        va_q, vb_q, vc_q;

	logic signed [AOW-1:0] e1 [3];
	logic signed [AOW-1:0] e2 [3];
	logic signed [BOW-1:0] d1u, d1v, d2u, d2v;
	logic [2:0]            lane3;
	logic [1:0]            lane;
	logic signed [AOW-1:0] opa;
	logic signed [BOW-1:0] opb;
	logic signed [PRW-1:0] prod;
	logic signed [PRW-1:0] prod_q;
	logic signed [NW-1:0]  acc_q, acc_nxt;
	logic signed [DW-1:0]  det_q;
	logic [2:0]            qidx_q;
	logic                  term_q;
	logic                  degen_q;
	logic [QW-1:0]         res_q [6];
	logic [2:0]            res_idx;

	tbt_pkg::div_req_t     div_req;
	logic [QW-1:0]         div_quo;
	logic                  div_done;

	logic                  m_tvalid_q;
	logic [tbt_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic                  m_tuser_q;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_tvalid_q || m_axis_tready;

	always_comb begin
		sa_mod = tbt_pkg::slot_mod(s_axis_tdata[CW-1:0], VERTEX_SLOTS);
		sb_mod = tbt_pkg::slot_mod(s_axis_tdata[2*CW-1:CW], VERTEX_SLOTS);
		sc_mod = tbt_pkg::slot_mod(s_axis_tdata[3*CW-1:2*CW], VERTEX_SLOTS);
		sa_ext = {{AW{1'b0}}, sa_mod};
		sb_ext = {{AW{1'b0}}, sb_mod};
		sc_ext = {{AW{1'b0}}, sc_mod};
		wr_vtx = s_axis_tdata[3*CW+VW-1:3*CW];
	end

	tbt_ram #(
		.WIDTH(VW),
		.DEPTH(VERTEX_SLOTS)
	) u_vtx_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(sa_ext[AW-1:0]),
		.wdata(wr_vtx),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Edges and UV deltas from the three captured corners.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e1[i] = $signed({vb_q[PW*i+PW-1], vb_q[PW*i +: PW]})
				- $signed({va_q[PW*i+PW-1], va_q[PW*i +: PW]});
			e2[i] = $signed({vc_q[PW*i+PW-1], vc_q[PW*i +: PW]})
				- $signed({va_q[PW*i+PW-1], va_q[PW*i +: PW]});
		end
		d1u = $signed({vb_q[3*PW+TW-1], vb_q[3*PW +: TW]})
			- $signed({va_q[3*PW+TW-1], va_q[3*PW +: TW]});
		d1v = $signed({vb_q[VW-1], vb_q[VW-1 -: TW]})
			- $signed({va_q[VW-1], va_q[VW-1 -: TW]});
		d2u = $signed({vc_q[3*PW+TW-1], vc_q[3*PW +: TW]})
			- $signed({va_q[3*PW+TW-1], va_q[3*PW +: TW]});
		d2v = $signed({vc_q[VW-1], vc_q[VW-1 -: TW]})
			- $signed({va_q[VW-1], va_q[VW-1 -: TW]});
	end

	// Operand selection for the shared multiplier. Even terms load the
	// accumulator, odd terms are subtracted from it.
	always_comb begin
		lane3 = (qidx_q >= tbt_pkg::QTY_BIT0) ? (qidx_q - tbt_pkg::QTY_BIT0)
			: (qidx_q - 3'd1);
		lane  = lane3[1:0];
		opa   = '0;
		opb   = '0;
		if (qidx_q == tbt_pkg::QTY_DET) begin
			opa = term_q ? AOW'(d2u) : AOW'(d1u);
			opb = term_q ? d1v : d2v;
		end else if (qidx_q < tbt_pkg::QTY_BIT0) begin
			opa = term_q ? e2[lane] : e1[lane];
			opb = term_q ? d1v : d2v;
		end else if (qidx_q <= tbt_pkg::QTY_LAST) begin
			opa = term_q ? e1[lane] : e2[lane];
			opb = term_q ? d2u : d1u;
		end
		prod    = opa * opb;
		acc_nxt = term_q ? (acc_q - NW'(prod_q)) : NW'(prod_q);
		res_idx = qidx_q - 3'd1;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tbt_pkg::ST_IDLE: begin
				if (in_xfer && s_axis_tuser == tbt_pkg::REQ_COMPUTE) begin
					state_d = tbt_pkg::ST_RD_A;
				end
			end
			tbt_pkg::ST_RD_A: state_d = tbt_pkg::ST_RD_B;
			tbt_pkg::ST_RD_B: state_d = tbt_pkg::ST_RD_C;
			tbt_pkg::ST_RD_C: state_d = tbt_pkg::ST_CAP;
			tbt_pkg::ST_CAP:  state_d = tbt_pkg::ST_MUL;
			tbt_pkg::ST_MUL:  state_d = tbt_pkg::ST_ACC;
			tbt_pkg::ST_ACC: begin
				if (!term_q) begin
					state_d = tbt_pkg::ST_MUL;
				end else if (qidx_q == tbt_pkg::QTY_DET) begin
					state_d = (acc_nxt == '0) ? tbt_pkg::ST_OUT : tbt_pkg::ST_MUL;
				end else begin
					state_d = tbt_pkg::ST_DIV;
				end
			end
			tbt_pkg::ST_DIV:  state_d = tbt_pkg::ST_DWAIT;
			tbt_pkg::ST_DWAIT: begin
				if (div_done) begin
					state_d = (qidx_q == tbt_pkg::QTY_LAST) ? tbt_pkg::ST_OUT
						: tbt_pkg::ST_MUL;
				end
			end
			tbt_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = tbt_pkg::ST_IDLE;
				end
			end
			default: state_d = tbt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		ram_we        = 1'b0;
		ram_raddr     = a_q;
		div_req.start = 1'b0;
		div_req.num   = acc_q;
		div_req.den   = det_q;
		unique case (state_q)
			tbt_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				ram_we        = in_xfer && s_axis_tuser == tbt_pkg::REQ_WRITE;
			end
			tbt_pkg::ST_RD_B: ram_raddr = b_q;
			tbt_pkg::ST_RD_C: ram_raddr = c_q;
			tbt_pkg::ST_DIV:  div_req.start = 1'b1;
			default: begin
			end
		endcase
	end

	tbt_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.quo   (div_quo),
		.done  (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tbt_pkg::ST_IDLE;
			qidx_q     <= tbt_pkg::QTY_DET;
			term_q     <= 1'b0;
			degen_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == tbt_pkg::ST_IDLE && in_xfer) begin
				qidx_q  <= tbt_pkg::QTY_DET;
				term_q  <= 1'b0;
				degen_q <= 1'b0;
			end
			if (state_q == tbt_pkg::ST_ACC) begin
				term_q <= ~term_q;
				if (term_q && qidx_q == tbt_pkg::QTY_DET) begin
					qidx_q  <= qidx_q + 3'd1;
					degen_q <= (acc_nxt == '0);
				end
			end
			if (state_q == tbt_pkg::ST_DWAIT && div_done) begin
				qidx_q <= qidx_q + 3'd1;
			end
			if (state_q == tbt_pkg::ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tbt_pkg::ST_IDLE && in_xfer) begin
			a_q <= sa_ext[AW-1:0];
			b_q <= sb_ext[AW-1:0];
			c_q <= sc_ext[AW-1:0];
		end
		if (state_q == tbt_pkg::ST_RD_B) begin
			va_q <= ram_rdata;
		end
		if (state_q == tbt_pkg::ST_RD_C) begin
			vb_q <= ram_rdata;
		end
		if (state_q == tbt_pkg::ST_CAP) begin
			vc_q <= ram_rdata;
		end
		if (state_q == tbt_pkg::ST_MUL) begin
			prod_q <= prod;
		end
		if (state_q == tbt_pkg::ST_ACC) begin
			acc_q <= acc_nxt;
			if (term_q && qidx_q == tbt_pkg::QTY_DET) begin
				det_q <= DW'(acc_nxt);
			end
		end
		if (state_q == tbt_pkg::ST_DWAIT && div_done) begin
			res_q[res_idx] <= div_quo;
		end
		if (state_q == tbt_pkg::ST_OUT && out_free) begin
			m_tuser_q <= degen_q;
			m_tdata_q <= degen_q ? '0
				: {res_q[5], res_q[4], res_q[3], res_q[2], res_q[1], res_q[0]};
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

endmodule

// ===== src/tbt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module tbt_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/tbt_div.sv =====
// ----------------------------------------------------------------------------
// Tangent/bitangent divider
// Radix-2 restoring divider: numerator scaled by 2^12 over the determinant,
// truncated toward zero and saturated to a signed 32-bit result.
// ----------------------------------------------------------------------------
module tbt_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tbt_pkg::div_req_t               req,
	output logic [tbt_pkg::QUO_W-1:0]       quo,
	output logic                            done
);

	localparam int SH_W  = tbt_pkg::NUM_W + tbt_pkg::FRAC_SH;
	localparam int REM_W = tbt_pkg::DEN_W + 1;
	localparam int QW    = tbt_pkg::QUO_W;
	localparam int CNT_W = $clog2(QW + 1);

	logic [tbt_pkg::NUM_W-1:0] nmag;
	logic [tbt_pkg::DEN_W-1:0] dmag;
	logic [SH_W-1:0]           shifted;
	logic [REM_W-1:0]          rem_sh;
	logic [REM_W-1:0]          den_ext;
	logic                      ge;

	logic                      busy_q;
	logic                      done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      neg_q;
	logic                      ovf_q;
	logic [REM_W-1:0]          rem_q;
	logic [QW-1:0]             quo_q;
	logic [tbt_pkg::DEN_W-1:0] dmag_q;

	always_comb begin
		nmag    = req.num[tbt_pkg::NUM_W-1] ? tbt_pkg::NUM_W'(-req.num)
			: tbt_pkg::NUM_W'(req.num);
		dmag    = req.den[tbt_pkg::DEN_W-1] ? tbt_pkg::DEN_W'(-req.den)
			: tbt_pkg::DEN_W'(req.den);
		shifted = {nmag, {tbt_pkg::FRAC_SH{1'b0}}};
		rem_sh  = {rem_q[REM_W-2:0], quo_q[QW-1]};
		den_ext = {1'b0, dmag_q};
		ge      = rem_sh >= den_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The quotient fits in 32 bits only when the high numerator bits stay
	// below the divisor; otherwise the result saturates.
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q  <= req.num[tbt_pkg::NUM_W-1] ^ req.den[tbt_pkg::DEN_W-1];
			dmag_q <= dmag;
			rem_q  <= REM_W'(shifted[SH_W-1:QW]);
			ovf_q  <= REM_W'(shifted[SH_W-1:QW]) >= {1'b0, dmag};
			quo_q  <= shifted[QW-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? (rem_sh - den_ext) : rem_sh;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	always_comb begin
		if (!neg_q) begin
			quo = (ovf_q || quo_q[QW-1]) ? {1'b0, {(QW-1){1'b1}}} : quo_q;
		end else begin
			quo = (ovf_q || (quo_q[QW-1] && (quo_q[QW-2:0] != '0)))
				? {1'b1, {(QW-1){1'b0}}} : QW'(-quo_q);
		end
	end

	assign done = done_q;

endmodule

// ===== src/tbt_checker.sv =====
// ----------------------------------------------------------------------------
// Triangle tangent/bitangent checker
// Port-level properties of the tangent/bitangent block, bound to the top level.
// ----------------------------------------------------------------------------
`include "triangle_tangent_bitangent_defines.svh"

module tbt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [tbt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input logic                           s_axis_tuser,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [tbt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                           m_axis_tuser
);

	// A result only appears at the end of a computation, never while idle.
	`TBT_ASSERT_SAME(a_result_after_work, $rose(m_axis_tvalid), !$past(s_axis_tready), "result appeared while the block was idle")

	// A compute transfer keeps the input side closed on the following cycle.
	`TBT_ASSERT_NEXT(a_compute_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser == tbt_pkg::REQ_COMPUTE, !s_axis_tready, "input ready right after a compute transfer")

	// A degenerate triangle carries all-zero vectors.
	`TBT_ASSERT_SAME(a_degen_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "degenerate result with nonzero vectors")

	// A stalled result holds its value.
	`TBT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

	logic unused_in;
	assign unused_in = ^s_axis_tdata;

endmodule

bind triangle_tangent_bitangent tbt_checker u_tbt_checker (.*);

// ===== sim/tb_triangle_tangent_bitangent.sv =====
// ----------------------------------------------------------------------------
// Testbench for the triangle tangent/bitangent unit
// Writes vertices and computes triangles through the input stream. Each
// result is checked against a predictor that keeps its own copy of the
// vertex table and does the exact integer arithmetic. Directed triangles
// cover the extremes, saturation and the zero determinant. Random traffic
// follows, with idle cycles drawn on both streams.
// ----------------------------------------------------------------------------
module tb_triangle_tangent_bitangent;

	localparam int SLOTS = 1024;

	typedef struct packed {
		logic [tbt_pkg::OUT_DATA_W-1:0] vec;
		logic                           degen;
	} tangent_frame_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [tbt_pkg::IN_DATA_W-1:0]  s_axis_tdata;
	logic                           s_axis_tuser;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [tbt_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                           m_axis_tuser;

	// Predictor copy of the vertex table.
	logic signed [tbt_pkg::POS_W-1:0] vtx_pos[SLOTS][3];
	logic signed [tbt_pkg::TEX_W-1:0] vtx_tex[SLOTS][2];
	int                      filled_slots[$];
	bit                      slot_filled[SLOTS];

	tangent_frame_t expected_frames[$];
	int             errors;
	bit             tx_idle_en;
	bit             rx_idle_en;
	int             rx_wait;
	int             rx_count;

	triangle_tangent_bitangent #(.VERTEX_SLOTS(SLOTS)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic [tbt_pkg::QUO_W-1:0] sat_quotient(input longint num,
		input longint den);
		longint q;
		q = (num * 4096) / den;
		if (q > 64'sd2147483647) begin
			q = 64'sd2147483647;
		end
		if (q < -64'sd2147483648) begin
			q = -64'sd2147483648;
		end
		return q[tbt_pkg::QUO_W-1:0];
	endfunction

	function automatic tangent_frame_t tangent_of(input int a, input int b, input int c);
		tangent_frame_t f;
		longint e1[3];
		longint e2[3];
		longint d1u, d1v, d2u, d2v, det;
		for (int i = 0; i < 3; i++) begin
			e1[i] = longint'(vtx_pos[b][i]) - longint'(vtx_pos[a][i]);
			e2[i] = longint'(vtx_pos[c][i]) - longint'(vtx_pos[a][i]);
		end
		d1u = longint'(vtx_tex[b][0]) - longint'(vtx_tex[a][0]);
		d1v = longint'(vtx_tex[b][1]) - longint'(vtx_tex[a][1]);
		d2u = longint'(vtx_tex[c][0]) - longint'(vtx_tex[a][0]);
		d2v = longint'(vtx_tex[c][1]) - longint'(vtx_tex[a][1]);
		det = d1u * d2v - d2u * d1v;
		f.vec = '0;
		f.degen = (det == 0);
		if (det != 0) begin
			for (int i = 0; i < 3; i++) begin
				f.vec[i*tbt_pkg::QUO_W +: tbt_pkg::QUO_W] =
					sat_quotient(d2v * e1[i] - d1v * e2[i], det);
				f.vec[(3+i)*tbt_pkg::QUO_W +: tbt_pkg::QUO_W] =
					sat_quotient(d1u * e2[i] - d2u * e1[i], det);
			end
		end
		return f;
	endfunction

	// Drives one item, waits for its transfer and updates the predictor.
	task automatic send_item(input logic kind, input logic [9:0] a, input logic [9:0] b,
		input logic [9:0] c, input logic [31:0] px, input logic [31:0] py,
		input logic [31:0] pz, input logic [15:0] tu, input logic [15:0] tv);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, 6) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {2'b00, tv, tu, pz, py, px, c, b, a};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (kind == tbt_pkg::REQ_WRITE) begin
			vtx_pos[a][0] = px;
			vtx_pos[a][1] = py;
			vtx_pos[a][2] = pz;
			vtx_tex[a][0] = tu;
			vtx_tex[a][1] = tv;
			if (!slot_filled[a]) begin
				slot_filled[a] = 1'b1;
				filled_slots.push_back(int'(a));
			end
		end else begin
			expected_frames.push_back(tangent_of(int'(a), int'(b), int'(c)));
		end
	endtask

	task automatic put_vertex(input int slot, input logic [31:0] px, input logic [31:0] py,
		input logic [31:0] pz, input logic [15:0] tu, input logic [15:0] tv);
		send_item(tbt_pkg::REQ_WRITE, slot[9:0], 10'($urandom), 10'($urandom), px, py, pz,
			tu, tv);
	endtask

	task automatic ask_triangle(input int a, input int b, input int c);
		send_item(tbt_pkg::REQ_COMPUTE, a[9:0], b[9:0], c[9:0], $urandom, $urandom,
			$urandom, 16'($urandom), 16'($urandom));
	endtask

	task automatic drop_valid();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic test_directed();
		put_vertex(0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0);
		put_vertex(1, 32'h0001_0000, 32'h0, 32'h0, 16'h1000, 16'h0);
		put_vertex(2, 32'h0, 32'h0001_0000, 32'h0, 16'h0, 16'h1000);
		ask_triangle(0, 1, 2);
		// All three corners alike give a zero determinant.
		ask_triangle(0, 0, 0);
		put_vertex(1023, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h7fff, 16'h7fff);
		put_vertex(512, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000);
		put_vertex(5, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0, 16'h0);
		put_vertex(3, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h1, 16'h0);
		put_vertex(4, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'h0, 16'h1);
		// Unit determinant with full-range edges saturates both ways.
		ask_triangle(5, 3, 4);
		ask_triangle(3, 5, 4);
		ask_triangle(4, 3, 5);
		ask_triangle(1023, 512, 0);
		ask_triangle(512, 1023, 1);
		ask_triangle(2, 1023, 512);
		ask_triangle(1, 2, 0);
		drop_valid();
	endtask

	task automatic random_vertex();
		int slot;
		logic [31:0] p[3];
		logic [15:0] t[2];
		slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 31);
		for (int i = 0; i < 3; i++) begin
			case ($urandom_range(0, 3))
				0: p[i] = $urandom;
				1: p[i] = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
				default: p[i] = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
			endcase
		end
		for (int i = 0; i < 2; i++) begin
			// Small coordinates make tiny determinants and so saturation.
			t[i] = $urandom_range(0, 2) == 0 ? 16'($urandom) : 16'($signed($urandom_range(0, 8)) - 4);
		end
		put_vertex(slot, p[0], p[1], p[2], t[0], t[1]);
	endtask

	task automatic random_triangle();
		int n;
		n = filled_slots.size();
		ask_triangle(filled_slots[$urandom_range(0, n - 1)],
			filled_slots[$urandom_range(0, n - 1)], filled_slots[$urandom_range(0, n - 1)]);
	endtask

	task automatic test_random(input int count);
		for (int k = 0; k < count; k++) begin
			if (k % 64 == 0) begin
				tx_idle_en = $urandom_range(0, 2) != 0;
			end
			if ($urandom_range(0, 9) < 4) begin
				random_vertex();
			end else begin
				random_triangle();
			end
		end
		drop_valid();
	endtask

	// The sender holds off until every pending result has been taken.
	task automatic test_drain_pause();
		for (int k = 0; k < 4; k++) begin
			random_triangle();
		end
		drop_valid();
		wait (expected_frames.size() == 0);
		for (int k = 0; k < 4; k++) begin
			random_vertex();
			random_triangle();
		end
		drop_valid();
	endtask

	// Receiver side: ready pattern and result check.
	always @(negedge clk) begin
		if (rx_wait > 0) begin
			m_axis_tready <= 1'b0;
			rx_wait = rx_wait - 1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		tangent_frame_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_frames.size() == 0) begin
				$display("%0t: unexpected result tdata=%h tuser=%b", $time, m_axis_tdata,
					m_axis_tuser);
				errors++;
			end else begin
				want = expected_frames.pop_front();
				for (int i = 0; i < 6; i++) begin
					if (m_axis_tdata[i*tbt_pkg::QUO_W +: tbt_pkg::QUO_W]
						!== want.vec[i*tbt_pkg::QUO_W +: tbt_pkg::QUO_W]) begin
						$display("%0t: vector field %0d expected %h actual %h", $time, i,
							want.vec[i*tbt_pkg::QUO_W +: tbt_pkg::QUO_W],
							m_axis_tdata[i*tbt_pkg::QUO_W +: tbt_pkg::QUO_W]);
						errors++;
					end
				end
				if (m_axis_tuser !== want.degen) begin
					$display("%0t: degenerate expected %b actual %b", $time, want.degen,
						m_axis_tuser);
					errors++;
				end
			end
			rx_count++;
			if (rx_count % 32 == 0) begin
				rx_idle_en = $urandom_range(0, 2) != 0;
			end
			rx_wait = rx_idle_en ? $urandom_range(0, 6) : 0;
		end
	end

	initial begin
		#4000000;
		$display("FAIL triangle_tangent_bitangent");
		$finish;
	end

	initial begin
		errors        = 0;
		rx_wait       = 0;
		rx_count      = 0;
		tx_idle_en    = 1'b1;
		rx_idle_en    = 1'b1;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = tbt_pkg::REQ_WRITE;
		m_axis_tready = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_drain_pause();
		test_random(1300);
		wait (expected_frames.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0 && expected_frames.size() == 0) begin
			$display("PASS triangle_tangent_bitangent");
		end else begin
			$display("FAIL triangle_tangent_bitangent");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/tbt_pkg.sv
src/tbt_ram.sv
src/tbt_div.sv
src/triangle_tangent_bitangent.sv
src/tbt_checker.sv
sim/tb_triangle_tangent_bitangent.sv
